@@ hw/rtl/pgcs_pkg.sv @@
package pgcs_pkg;

    localparam logic [1:0] STAT_MEAN  = 2'd0;
    localparam logic [1:0] STAT_MIN   = 2'd1;
    localparam logic [1:0] STAT_MAX   = 2'd2;
    localparam logic [1:0] STAT_COUNT = 2'd3;

    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;
    localparam logic [1:0] ST_READ     = 2'd3;

    localparam logic MODE_POINT = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic [7:0] REG_STATISTIC   = 8'd0;
    localparam logic [7:0] REG_CLASS_MASK  = 8'd1;
    localparam logic [7:0] REG_ORIGIN_X    = 8'd2;
    localparam logic [7:0] REG_ORIGIN_Y    = 8'd3;
    localparam logic [7:0] REG_CELL_SIZE_X = 8'd4;
    localparam logic [7:0] REG_CELL_SIZE_Y = 8'd5;
    localparam logic [7:0] REG_GRID_COLS   = 8'd6;
    localparam logic [7:0] REG_GRID_ROWS   = 8'd7;

    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_D8F1;
    localparam int          DIV_STEPS   = 64;

    typedef struct packed {
        logic        mode;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
        logic [7:0]  point_class;
        logic [15:0] cell_index;
    } t_point_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] cell_value;
        logic [31:0] cell_count;
        logic        cell_empty;
    } t_result_beat;

    typedef struct packed {
        logic [7:0]  index;
        logic [63:0] data;
    } t_cfg_beat;

    typedef struct packed {
        logic [63:0] acc;
        logic [31:0] cnt;
    } t_cell;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVX,
        S_XEND,
        S_DIVY,
        S_MAP,
        S_FETCH,
        S_UPDATE,
        S_MEAN,
        S_MEND,
        S_RESULT
    } t_state;

endpackage

@@ hw/rtl/pgcs_stream_if.sv @@
interface pgcs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/point_grid_cell_statistics.sv @@
// Point grid cell statistics: bins points into a raster and keeps one statistic per cell.
// One beat at a time: stored point takes two 64-step divider passes, then cell
// read-modify-write; outside point the two passes; rejected point or read outside the
// grid goes straight to the result; read a cell fetch; mean read a fetch and a divider
// pass. A stalled result holds the next beat off. Synchronous active-low reset, then a
// clearing pass zeroes all MAX_COLS*MAX_ROWS cells; config writes taken throughout.
module point_grid_cell_statistics #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pgcs_stream_if.sink        i_cfg,
    pgcs_stream_if.sink        i_pt,
    pgcs_stream_if.source      o_res
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int PW    = CW + RW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    pgcs_pkg::t_state r_state, n_state;

    logic [1:0]  r_stat;
    logic [63:0] r_mask;
    logic [31:0] r_org_x, r_org_y;
    logic [30:0] r_size_x, r_size_y;
    logic [8:0]  r_grid_cols, r_grid_rows;

    logic [CW-1:0]    cols_c;
    logic [RW-1:0]    rows_c;
    logic [CW+RW-1:0] cells_c;

    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_addr;
    pgcs_pkg::t_cell r_mem [DEPTH];
    pgcs_pkg::t_cell r_rd;
    pgcs_pkg::t_cell cell_new;
    logic            mem_we;

    logic [63:0] r_dvd;
    logic [31:0] r_rem, r_dvs;
    logic [5:0]  r_step;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [31:0] div_rem;
    logic        div_last;

    logic        r_mode, r_neg, r_col_ok;
    logic [31:0] r_z, r_py;
    logic [CW-1:0] r_col;

    pgcs_pkg::t_result_beat r_res, r_out;
    logic                   r_out_valid;
    logic                   out_load;

    pgcs_pkg::t_point_beat pt;
    logic        accept;
    logic        class_ok;
    logic        read_out;
    logic [32:0] dx, mag_x, dy, mag_y;
    logic [31:0] dvs_x, dvs_y;

    logic          row_ok;
    logic [RW-1:0] map_row;
    logic [PW-1:0] map_idx;

    logic [63:0] z64;
    logic        cnt_full;
    logic [63:0] acc_mag;
    logic [31:0] acc_sat, cnt_sat, mean_val;
    logic        mean_big;

    assign pt     = i_pt.payload;
    assign accept = i_pt.valid && i_pt.ready;

    // grid size clamps
    always_comb begin
        if (r_grid_cols == 9'd0) begin
            cols_c = CW'(1);
        end else if (32'(r_grid_cols) > 32'(MAX_COLS)) begin
            cols_c = CW'(MAX_COLS);
        end else begin
            cols_c = CW'(r_grid_cols);
        end
        if (r_grid_rows == 9'd0) begin
            rows_c = RW'(1);
        end else if (32'(r_grid_rows) > 32'(MAX_ROWS)) begin
            rows_c = RW'(MAX_ROWS);
        end else begin
            rows_c = RW'(r_grid_rows);
        end
    end

    // config port
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat      <= pgcs_pkg::STAT_MEAN;
            r_mask      <= '0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_size_x    <= 31'd1;
            r_size_y    <= 31'd1;
            r_grid_cols <= 9'd256;
            r_grid_rows <= 9'd256;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                pgcs_pkg::REG_STATISTIC:   r_stat      <= i_cfg.payload.data[1:0];
                pgcs_pkg::REG_CLASS_MASK:  r_mask      <= i_cfg.payload.data;
                pgcs_pkg::REG_ORIGIN_X:    r_org_x     <= i_cfg.payload.data[31:0];
                pgcs_pkg::REG_ORIGIN_Y:    r_org_y     <= i_cfg.payload.data[31:0];
                pgcs_pkg::REG_CELL_SIZE_X: r_size_x    <= i_cfg.payload.data[30:0];
                pgcs_pkg::REG_CELL_SIZE_Y: r_size_y    <= i_cfg.payload.data[30:0];
                pgcs_pkg::REG_GRID_COLS:   r_grid_cols <= i_cfg.payload.data[8:0];
                pgcs_pkg::REG_GRID_ROWS:   r_grid_rows <= i_cfg.payload.data[8:0];
                default: ;
            endcase
        end
    end

    assign cells_c = (CW+RW)'(cols_c) * (CW+RW)'(rows_c);

    // divider step
    assign div_sh   = {r_rem, r_dvd[63]};
    assign div_ge   = div_sh >= {1'b0, r_dvs};
    assign div_rem  = div_ge ? 32'(div_sh - {1'b0, r_dvs}) : div_sh[31:0];
    assign div_last = r_step == 6'(pgcs_pkg::DIV_STEPS - 1);

    // input decode
    assign class_ok = (pt.point_class[7:6] == 2'b00) && r_mask[pt.point_class[5:0]];
    assign read_out = 32'(pt.cell_index) >= 32'(cells_c);
    assign dx    = {pt.point_x[31], pt.point_x} - {r_org_x[31], r_org_x};
    assign mag_x = dx[32] ? 33'(-dx) : dx;
    assign dy    = {r_org_y[31], r_org_y} - {r_py[31], r_py};
    assign mag_y = dy[32] ? 33'(-dy) : dy;
    assign dvs_x = (r_size_x == 31'd0) ? 32'd1 : {1'b0, r_size_x};
    assign dvs_y = (r_size_y == 31'd0) ? 32'd1 : {1'b0, r_size_y};

    // row from divider, cell address
    assign row_ok  = !(r_neg && (r_dvd != '0 || r_rem != '0)) && (r_dvd < 64'(rows_c));
    assign map_row = r_dvd[RW-1:0];
    assign map_idx = PW'(map_row) * PW'(cols_c) + PW'(r_col);

    // cell update and read values
    assign z64      = {{32{r_z[31]}}, r_z};
    assign cnt_full = &r_rd.cnt;
    always_comb begin
        cell_new = r_rd;
        if (r_rd.cnt == '0) begin
            cell_new.acc = z64;
            cell_new.cnt = 32'd1;
        end else if (r_stat == pgcs_pkg::STAT_MIN) begin
            if ($signed(z64) < $signed(r_rd.acc)) cell_new.acc = z64;
            if (!cnt_full) cell_new.cnt = r_rd.cnt + 32'd1;
        end else if (r_stat == pgcs_pkg::STAT_MAX) begin
            if ($signed(z64) > $signed(r_rd.acc)) cell_new.acc = z64;
            if (!cnt_full) cell_new.cnt = r_rd.cnt + 32'd1;
        end else if (!cnt_full) begin
            cell_new.acc = r_rd.acc + z64;
            cell_new.cnt = r_rd.cnt + 32'd1;
        end
    end

    assign acc_mag = r_rd.acc[63] ? 64'(-r_rd.acc) : r_rd.acc;
    always_comb begin
        if (r_rd.acc[63:31] == '0 || r_rd.acc[63:31] == '1) begin
            acc_sat = r_rd.acc[31:0];
        end else if (r_rd.acc[63]) begin
            acc_sat = 32'h8000_0000;
        end else begin
            acc_sat = 32'h7FFF_FFFF;
        end
    end
    assign cnt_sat  = r_rd.cnt[31] ? 32'h7FFF_FFFF : r_rd.cnt;
    assign mean_big = |r_dvd[63:31];
    always_comb begin
        if (r_neg) begin
            mean_val = mean_big ? 32'h8000_0000 : 32'(-r_dvd[31:0]);
        end else begin
            mean_val = mean_big ? 32'h7FFF_FFFF : r_dvd[31:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pgcs_pkg::S_CLEAR: if (r_clr == LAST_ADDR) n_state = pgcs_pkg::S_IDLE;
            pgcs_pkg::S_IDLE: begin
                if (accept) begin
                    if (pt.mode == pgcs_pkg::MODE_READ) begin
                        n_state = read_out ? pgcs_pkg::S_RESULT : pgcs_pkg::S_FETCH;
                    end else begin
                        n_state = class_ok ? pgcs_pkg::S_DIVX : pgcs_pkg::S_RESULT;
                    end
                end
            end
            pgcs_pkg::S_DIVX:  if (div_last) n_state = pgcs_pkg::S_XEND;
            pgcs_pkg::S_XEND:  n_state = pgcs_pkg::S_DIVY;
            pgcs_pkg::S_DIVY:  if (div_last) n_state = pgcs_pkg::S_MAP;
            pgcs_pkg::S_MAP:
                n_state = (r_col_ok && row_ok) ? pgcs_pkg::S_FETCH : pgcs_pkg::S_RESULT;
            pgcs_pkg::S_FETCH: n_state = pgcs_pkg::S_UPDATE;
            pgcs_pkg::S_UPDATE: begin
                if (r_mode == pgcs_pkg::MODE_READ && r_rd.cnt != '0
                        && r_stat == pgcs_pkg::STAT_MEAN) begin
                    n_state = pgcs_pkg::S_MEAN;
                end else begin
                    n_state = pgcs_pkg::S_RESULT;
                end
            end
            pgcs_pkg::S_MEAN:  if (div_last) n_state = pgcs_pkg::S_MEND;
            pgcs_pkg::S_MEND:  n_state = pgcs_pkg::S_RESULT;
            pgcs_pkg::S_RESULT: if (out_load) n_state = pgcs_pkg::S_IDLE;
            default: n_state = pgcs_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_pt.ready = r_state == pgcs_pkg::S_IDLE;
        mem_we     = (r_state == pgcs_pkg::S_CLEAR)
                  || (r_state == pgcs_pkg::S_UPDATE && r_mode == pgcs_pkg::MODE_POINT);
        out_load   = (r_state == pgcs_pkg::S_RESULT) && (!r_out_valid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pgcs_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pgcs_pkg::S_CLEAR) r_clr <= r_clr + AW'(1);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[(r_state == pgcs_pkg::S_CLEAR) ? r_clr : r_addr] <=
                (r_state == pgcs_pkg::S_CLEAR) ? '0 : cell_new;
        end
        r_rd <= r_mem[r_addr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= r_res;
        unique case (r_state)
            pgcs_pkg::S_IDLE: begin
                if (accept) begin
                    r_mode <= pt.mode;
                    r_z    <= pt.point_z;
                    r_py   <= pt.point_y;
                    r_dvd  <= 64'(mag_x);
                    r_rem  <= '0;
                    r_dvs  <= dvs_x;
                    r_step <= '0;
                    r_neg  <= dx[32];
                    r_addr <= AW'(pt.cell_index);
                    if (pt.mode == pgcs_pkg::MODE_READ) begin
                        r_res <= '{status: pgcs_pkg::ST_READ,
                                   cell_value: pgcs_pkg::EMPTY_VALUE,
                                   cell_count: 32'd0,
                                   cell_empty: 1'b1};
                    end else if (!class_ok) begin
                        r_res <= '{status: pgcs_pkg::ST_REJECTED,
                                   cell_value: 32'd0,
                                   cell_count: 32'd0,
                                   cell_empty: 1'b0};
                    end else begin
                        r_res <= '0;
                    end
                end
            end
            pgcs_pkg::S_DIVX, pgcs_pkg::S_DIVY, pgcs_pkg::S_MEAN: begin
                r_dvd  <= {r_dvd[62:0], div_ge};
                r_rem  <= div_rem;
                r_step <= r_step + 6'd1;
            end
            pgcs_pkg::S_XEND: begin
                r_col_ok <= !(r_neg && (r_dvd != '0 || r_rem != '0))
                         && (r_dvd < 64'(cols_c));
                r_col    <= r_dvd[CW-1:0];
                r_dvd    <= 64'(mag_y);
                r_rem    <= '0;
                r_dvs    <= dvs_y;
                r_step   <= '0;
                r_neg    <= dy[32];
            end
            pgcs_pkg::S_MAP: begin
                r_addr <= AW'(map_idx);
                if (!(r_col_ok && row_ok)) r_res.status <= pgcs_pkg::ST_OUTSIDE;
            end
            pgcs_pkg::S_UPDATE: begin
                if (r_mode == pgcs_pkg::MODE_READ && r_rd.cnt != '0) begin
                    r_res.cell_count <= r_rd.cnt;
                    r_res.cell_empty <= 1'b0;
                    r_dvd  <= acc_mag + 64'(r_rd.cnt[31:1]);
                    r_rem  <= '0;
                    r_dvs  <= r_rd.cnt;
                    r_step <= '0;
                    r_neg  <= r_rd.acc[63];
                    if (r_stat == pgcs_pkg::STAT_COUNT) begin
                        r_res.cell_value <= cnt_sat;
                    end else begin
                        r_res.cell_value <= acc_sat;
                    end
                end
            end
            pgcs_pkg::S_MEND: r_res.cell_value <= mean_val;
            default: ;
        endcase
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule
